FILE: rtl/drst_pkg.sv
`timescale 1ns / 1ps

package drst_pkg;

    // Grid limits
    localparam int MAX_ROWS  = 64;
    localparam int MAX_COLS  = 256;

    // Field and register widths
    localparam int ROW_W     = $clog2(MAX_ROWS);
    localparam int COL_W     = $clog2(MAX_COLS);
    localparam int ROW_CNT_W = ROW_W + 1;
    localparam int COL_CNT_W = COL_W + 1;
    localparam int EDGE_W    = 16;
    localparam int SPAN_W    = 2 * COL_W;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = COL_CNT_W;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = CFG_IDX_W'(1);

    localparam logic [ROW_CNT_W-1:0] ROW_COUNT_RESET = ROW_CNT_W'(24);
    localparam logic [COL_CNT_W-1:0] COL_COUNT_RESET = COL_CNT_W'(80);

    // Command codes
    localparam logic [1:0] CMD_MARK    = 2'd0;
    localparam logic [1:0] CMD_COLLECT = 2'd1;
    localparam logic [1:0] CMD_CLEAR   = 2'd2;

    // Controller to datapath
    typedef struct packed {
        logic load_rect;
        logic init_walk;
        logic clear_store;
        logic issue_mark;
        logic issue_walk;
        logic flush;
    } drst_ctl_t;

    // Datapath to controller
    typedef struct packed {
        logic grid_empty;
        logic rect_empty;
        logic no_rows;
        logic last_row;
    } drst_sts_t;

endpackage

FILE: rtl/drst_ram.sv
`timescale 1ns / 1ps

module drst_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/drst_datapath.sv
`timescale 1ns / 1ps

module drst_datapath (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  drst_pkg::drst_ctl_t                     ctl,
    output drst_pkg::drst_sts_t                     sts,
    input  logic                                    cfg_wr,
    input  logic [drst_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [drst_pkg::CFG_DATA_W-1:0]         cfg_data,
    input  logic signed [drst_pkg::EDGE_W-1:0]      rect_top,
    input  logic signed [drst_pkg::EDGE_W-1:0]      rect_left,
    input  logic signed [drst_pkg::EDGE_W-1:0]      rect_bottom,
    input  logic signed [drst_pkg::EDGE_W-1:0]      rect_right,
    output logic [drst_pkg::ROW_W-1:0]              region_top,
    output logic [drst_pkg::COL_W-1:0]              region_left,
    output logic [drst_pkg::ROW_W-1:0]              region_bottom,
    output logic [drst_pkg::COL_W-1:0]              region_right,
    output logic                                    last,
    output logic                                    region_valid
);

    import drst_pkg::*;

    // Clamp an edge into [0, hi]
    function automatic logic [COL_CNT_W-1:0] clamp_edge(
        input logic signed [EDGE_W-1:0] v,
        input logic [COL_CNT_W-1:0]     hi
    );
        logic [EDGE_W-1:0] hi_ext;
        hi_ext = EDGE_W'(hi);
        if (v[EDGE_W-1])
            return '0;
        else if ($unsigned(v) > hi_ext)
            return hi;
        else
            return v[COL_CNT_W-1:0];
    endfunction

    logic [ROW_CNT_W-1:0] row_count_reg;
    logic [COL_CNT_W-1:0] col_count_reg;
    logic [ROW_CNT_W-1:0] row_cfg;
    logic [COL_CNT_W-1:0] col_cfg;

    logic [MAX_ROWS-1:0]  dirty_reg;

    logic [ROW_W-1:0]     row_ptr_reg;
    logic [ROW_W-1:0]     end_row_reg;
    logic [COL_W-1:0]     rect_left_reg;
    logic [COL_W-1:0]     rect_right_reg;

    logic                 s1_mark_reg;
    logic                 s1_walk_reg;
    logic [ROW_W-1:0]     s1_row_reg;

    logic                 open_reg;
    logic [ROW_W-1:0]     cur_top_reg;
    logic [ROW_W-1:0]     cur_bot_reg;
    logic [COL_W-1:0]     cur_left_reg;
    logic [COL_W-1:0]     cur_right_reg;

    logic                 region_valid_reg;
    logic                 last_reg;
    logic [ROW_W-1:0]     region_top_reg;
    logic [ROW_W-1:0]     region_bottom_reg;
    logic [COL_W-1:0]     region_left_reg;
    logic [COL_W-1:0]     region_right_reg;

    logic [COL_CNT_W-1:0] row_hi;
    logic [COL_CNT_W-1:0] col_hi;
    logic [ROW_W-1:0]     top_c;
    logic [ROW_W-1:0]     bot_c;
    logic [COL_W-1:0]     left_c;
    logic [COL_W-1:0]     right_c;

    logic                 issue;
    logic [SPAN_W-1:0]    span_rd;
    logic [COL_W-1:0]     span_left;
    logic [COL_W-1:0]     span_right;
    logic                 row_is_dirty;
    logic [COL_W-1:0]     new_left;
    logic [COL_W-1:0]     new_right;
    logic                 joins;
    logic                 walk_hit;
    logic                 emit_run;
    logic                 emit_flush;
    logic                 emit;

    // Rectangle clamp and status
    assign row_hi  = COL_CNT_W'(row_count_reg) - COL_CNT_W'(1);
    assign col_hi  = col_count_reg - COL_CNT_W'(1);
    assign top_c   = ROW_W'(clamp_edge(rect_top, row_hi));
    assign bot_c   = ROW_W'(clamp_edge(rect_bottom, row_hi));
    assign left_c  = COL_W'(clamp_edge(rect_left, col_hi));
    assign right_c = COL_W'(clamp_edge(rect_right, col_hi));

    assign sts.grid_empty = (row_count_reg == '0) || (col_count_reg == '0);
    assign sts.rect_empty = (top_c > bot_c) || (left_c > right_c);
    assign sts.no_rows    = (row_count_reg == '0);
    assign sts.last_row   = (row_ptr_reg == end_row_reg);

    assign row_cfg = cfg_data[ROW_CNT_W-1:0];
    assign col_cfg = cfg_data[COL_CNT_W-1:0];

    // Span store: read at issue, merge and write back in the following cycle
    assign issue = ctl.issue_mark || ctl.issue_walk;

    drst_ram #(
        .WIDTH (SPAN_W),
        .DEPTH (MAX_ROWS)
    ) u_span_ram (
        .clk     (clk),
        .wr_en   (s1_mark_reg),
        .wr_addr (s1_row_reg),
        .wr_data ({new_left, new_right}),
        .rd_en   (issue),
        .rd_addr (row_ptr_reg),
        .rd_data (span_rd)
    );

    assign span_left    = span_rd[SPAN_W-1:COL_W];
    assign span_right   = span_rd[COL_W-1:0];
    assign row_is_dirty = dirty_reg[s1_row_reg];

    assign new_left  = (row_is_dirty && (span_left < rect_left_reg)) ? span_left : rect_left_reg;
    assign new_right = (row_is_dirty && (span_right > rect_right_reg)) ? span_right
                                                                       : rect_right_reg;

    assign joins = open_reg && (span_left == cur_left_reg) && (span_right == cur_right_reg)
                   && ((ROW_CNT_W'(cur_bot_reg) + ROW_CNT_W'(1)) == ROW_CNT_W'(s1_row_reg));
    assign walk_hit   = s1_walk_reg && row_is_dirty;
    assign emit_run   = walk_hit && open_reg && !joins;
    assign emit_flush = ctl.flush && open_reg;
    assign emit       = emit_run || emit_flush;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg    <= ROW_COUNT_RESET;
            col_count_reg    <= COL_COUNT_RESET;
            dirty_reg        <= '0;
            s1_mark_reg      <= 1'b0;
            s1_walk_reg      <= 1'b0;
            open_reg         <= 1'b0;
            region_valid_reg <= 1'b0;
        end
        else
        begin
            s1_mark_reg      <= ctl.issue_mark;
            s1_walk_reg      <= ctl.issue_walk;
            region_valid_reg <= emit;

            if (cfg_wr && (cfg_index == REG_ROW_COUNT))
            begin
                row_count_reg <= (row_cfg > ROW_CNT_W'(MAX_ROWS)) ? ROW_CNT_W'(MAX_ROWS)
                                                                  : row_cfg;
            end
            if (cfg_wr && (cfg_index == REG_COL_COUNT))
            begin
                col_count_reg <= (col_cfg > COL_CNT_W'(MAX_COLS)) ? COL_CNT_W'(MAX_COLS)
                                                                  : col_cfg;
            end

            priority if (ctl.clear_store ||
                         (cfg_wr && ((cfg_index == REG_ROW_COUNT) ||
                                     (cfg_index == REG_COL_COUNT))))
            begin
                dirty_reg <= '0;
            end
            else if (s1_mark_reg)
            begin
                dirty_reg[s1_row_reg] <= 1'b1;
            end
            else
            begin
                dirty_reg <= dirty_reg;
            end

            priority if (ctl.init_walk || ctl.flush)
            begin
                open_reg <= 1'b0;
            end
            else if (walk_hit)
            begin
                open_reg <= 1'b1;
            end
            else
            begin
                open_reg <= open_reg;
            end
        end
    end

    // Pointers, run under construction and result payload
    always_ff @(posedge clk)
    begin
        if (ctl.load_rect)
        begin
            row_ptr_reg    <= top_c;
            end_row_reg    <= bot_c;
            rect_left_reg  <= left_c;
            rect_right_reg <= right_c;
        end
        else if (ctl.init_walk)
        begin
            row_ptr_reg <= '0;
            end_row_reg <= ROW_W'(row_count_reg - ROW_CNT_W'(1));
        end
        else if (issue)
        begin
            row_ptr_reg <= row_ptr_reg + ROW_W'(1);
        end

        if (issue)
        begin
            s1_row_reg <= row_ptr_reg;
        end

        if (walk_hit)
        begin
            cur_bot_reg <= s1_row_reg;
            if (!joins)
            begin
                cur_top_reg   <= s1_row_reg;
                cur_left_reg  <= span_left;
                cur_right_reg <= span_right;
            end
        end

        if (emit)
        begin
            region_top_reg    <= cur_top_reg;
            region_bottom_reg <= cur_bot_reg;
            region_left_reg   <= cur_left_reg;
            region_right_reg  <= cur_right_reg;
            last_reg          <= emit_flush;
        end
    end

    assign region_valid  = region_valid_reg;
    assign region_top    = region_top_reg;
    assign region_bottom = region_bottom_reg;
    assign region_left   = region_left_reg;
    assign region_right  = region_right_reg;
    assign last          = last_reg;

    a_one_stage1_op: assert property (@(posedge clk) disable iff (!rst_n)
        !(s1_mark_reg && s1_walk_reg))
        else $error("mark and walk both occupy the span stage");

    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (region_valid_reg && last_reg) |=> !region_valid_reg)
        else $error("region emitted right after the final region");

    a_region_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        region_valid_reg |-> ((region_top_reg <= region_bottom_reg) &&
                              (region_left_reg <= region_right_reg)))
        else $error("emitted region has reversed edges");

endmodule

FILE: rtl/drst_ctrl.sv
`timescale 1ns / 1ps

module drst_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [1:0]          cmd,
    input  drst_pkg::drst_sts_t sts,
    output drst_pkg::drst_ctl_t ctl,
    output logic                busy
);

    import drst_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MARK,
        S_MARK_DRAIN,
        S_WALK,
        S_WALK_DRAIN,
        S_FLUSH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    priority if (cmd == CMD_MARK)
                    begin
                        if (!sts.grid_empty && !sts.rect_empty)
                        begin
                            ctl.load_rect = 1'b1;
                            state_next    = S_MARK;
                        end
                    end
                    else if (cmd == CMD_COLLECT)
                    begin
                        ctl.init_walk = 1'b1;
                        state_next    = sts.no_rows ? S_FLUSH : S_WALK;
                    end
                    else if (cmd == CMD_CLEAR)
                    begin
                        ctl.clear_store = 1'b1;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_MARK:
            begin
                ctl.issue_mark = 1'b1;
                if (sts.last_row)
                    state_next = S_MARK_DRAIN;
            end
            S_MARK_DRAIN:
            begin
                state_next = S_IDLE;
            end
            S_WALK:
            begin
                ctl.issue_walk = 1'b1;
                if (sts.last_row)
                    state_next = S_WALK_DRAIN;
            end
            S_WALK_DRAIN:
            begin
                state_next = S_FLUSH;
            end
            S_FLUSH:
            begin
                ctl.flush  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != S_IDLE);
        end
    end

    assign busy = busy_reg;

    a_collect_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy_reg && (cmd == CMD_COLLECT)) |=> busy_reg)
        else $error("collect accepted without raising busy");

    a_flush_ends: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.flush |=> !busy_reg)
        else $error("busy still high after flush");

    a_no_issue_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> !(ctl.issue_mark || ctl.issue_walk || ctl.flush))
        else $error("row walk issued while idle");

endmodule

FILE: rtl/dirty_row_span_tracker.sv
// Mark: busy through S_MARK for each covered row after clamping (1..64) and S_MARK_DRAIN;
//   one read-merge-write of the span RAM per row. Empty marks, clear and code 3 never raise busy.
// Collect: busy through S_WALK per row in use, S_WALK_DRAIN and S_FLUSH, or only S_FLUSH
//   when row_count is 0; regions stream out one per cycle at most, each strobe lasting one
//   cycle, the final one in the first cycle with busy low again. The receiver cannot stall.
// Reset: row_count 24, col_count 80, every dirty bit cleared at once; no clearing pass.
`timescale 1ns / 1ps

module dirty_row_span_tracker (
    input  logic                                clk,
    input  logic                                rst_n,

    // Command channel
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          cmd,
    input  logic signed [drst_pkg::EDGE_W-1:0]  rect_top,
    input  logic signed [drst_pkg::EDGE_W-1:0]  rect_left,
    input  logic signed [drst_pkg::EDGE_W-1:0]  rect_bottom,
    input  logic signed [drst_pkg::EDGE_W-1:0]  rect_right,

    // Configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [drst_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [drst_pkg::CFG_DATA_W-1:0]     cfg_data,

    // Region results
    output logic                                region_valid,
    output logic [drst_pkg::ROW_W-1:0]          region_top,
    output logic [drst_pkg::COL_W-1:0]          region_left,
    output logic [drst_pkg::ROW_W-1:0]          region_bottom,
    output logic [drst_pkg::COL_W-1:0]          region_right,
    output logic                                last
);

    import drst_pkg::*;

    drst_ctl_t ctl;
    drst_sts_t sts;
    logic      cfg_wr;

    // Take configuration transactions only while no command is in flight or
    // being offered; either size write also empties the dirty store.
    assign cfg_ready = ~busy && ~start;
    assign cfg_wr    = cfg_valid && cfg_ready;

    // Sequencer: decode the command, step the row pointer across the covered
    // rows (mark) or across all rows in use (collect), then drain the span
    // stage and, for collect, flush the last open region.
    drst_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .sts   (sts),
        .ctl   (ctl),
        .busy  (busy)
    );

    // Datapath: size registers, edge clamp, dirty bits in flops, span RAM
    // with a registered read-merge-write stage, run merger and result register.
    drst_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .sts           (sts),
        .cfg_wr        (cfg_wr),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .rect_top      (rect_top),
        .rect_left     (rect_left),
        .rect_bottom   (rect_bottom),
        .rect_right    (rect_right),
        .region_top    (region_top),
        .region_left   (region_left),
        .region_bottom (region_bottom),
        .region_right  (region_right),
        .last          (last),
        .region_valid  (region_valid)
    );

endmodule
